### design/image_gradient_magnitude_defines.svh
// Assertion macros shared by the gradient magnitude RTL.
`ifndef IMAGE_GRADIENT_MAGNITUDE_DEFINES_SVH
`define IMAGE_GRADIENT_MAGNITUDE_DEFINES_SVH

`ifndef ASSERT_OFF
`define IGM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IGM_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define IGM_ASSERT(name, prop, msg)
`define IGM_ASSERT_NEVER(name, expr, msg)
`endif

`endif

### design/igm_pkg.sv
// Shared constants, types and helpers for the gradient magnitude block.
package igm_pkg;

    localparam int unsigned CFG_W        = 11;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned DIM_W        = 14;
    localparam int unsigned DIM_MIN      = 2;
    localparam int unsigned PIX_W        = 15;
    localparam int unsigned GRAD_W       = 16;
    localparam int unsigned MAG_W        = 16;
    localparam int unsigned SQ_W         = 30;
    localparam int unsigned RAD_W        = 32;
    localparam int unsigned ROOT_STEPS   = RAD_W / 2;
    localparam int unsigned REM_W        = MAG_W + 1;
    localparam int unsigned MAG_MAX      = 46341;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned DEF_MAX_COLS = 1024;
    localparam int unsigned DEF_MAX_ROWS = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET     = 11'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     frame_end;
    } t_grad_item;

    typedef struct packed {
        logic       valid;
        t_grad_item item;
    } t_grad_push;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD_NBR,
        F_RD_VERT,
        F_CALC
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_SUM,
        B_ROOT,
        B_ROUND
    } t_back_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int unsigned hi);
        logic [DIM_W-1:0] ve;
        ve = DIM_W'(v);
        if (ve < DIM_W'(DIM_MIN)) begin
            return DIM_W'(DIM_MIN);
        end else if (32'(ve) > hi) begin
            return DIM_W'(hi);
        end
        return ve;
    endfunction

endpackage

### design/igm_front.sv
// Front end: raster position tracking, line stores and x/y differences.
`include "image_gradient_magnitude_defines.svh"

module igm_front
    import igm_pkg::*;
#(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [PIX_W-1:0]     i_sample,
    input  logic                 i_queue_full,
    output t_grad_push           o_push
);

    localparam int unsigned CW    = $clog2(MAX_COLS);
    localparam int unsigned RW    = $clog2(MAX_ROWS);
    localparam int unsigned DEPTH = 2 * MAX_COLS;
    localparam int unsigned AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic bank, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = bank ? AW'(MAX_COLS) : '0;
        return base + AW'(col);
    endfunction

    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_col_count;

    t_front_state r_state, n_state;
    logic          r_older_bank;
    logic [RW-1:0] r_row_index;
    logic [CW-1:0] r_col_index;
    logic          r_drain_pending;

    logic             r_kind;
    logic [PIX_W-1:0] r_sample;
    logic             r_last;
    logic [AW-1:0]    r_addr_l, r_addr_r, r_addr_u, r_addr_c, r_addr_w;

    logic [PIX_W-1:0] r_line_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_a, r_rd_b;
    logic [PIX_W-1:0] r_left, r_right;

    logic [DIM_W-1:0] rows, cols;
    logic             row_end, last_row, newer;
    logic             take, is_drain, is_pixel, work, store_first;
    logic             last_pixel;
    logic [CW-1:0]    col_l, col_r;
    logic             upper_bank;
    logic             rd_en;
    logic [AW-1:0]    rd_addr_a, rd_addr_b;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic             push;

    assign rows     = clamp_dim(r_row_count, MAX_ROWS);
    assign cols     = clamp_dim(r_col_count, MAX_COLS);
    assign row_end  = DIM_W'(r_col_index) >= (cols - DIM_W'(1));
    assign last_row = DIM_W'(r_row_index) >= (rows - DIM_W'(1));
    assign newer    = ~r_older_bank;

    assign o_in_ready  = (r_state == F_IDLE);
    assign take        = i_in_valid && o_in_ready;
    assign is_drain    = (i_action == ACT_DRAIN) && r_drain_pending;
    assign is_pixel    = (i_action == ACT_PIXEL) && !r_drain_pending;
    assign work        = take && (is_drain || (is_pixel && (r_row_index != '0)));
    assign store_first = take && is_pixel && (r_row_index == '0);
    assign last_pixel  = take && is_pixel && row_end && last_row;

    always_comb begin
        if (r_col_index == '0) begin
            col_l = '0;
            col_r = CW'(1);
        end else if (row_end) begin
            col_l = r_col_index - CW'(1);
            col_r = r_col_index;
        end else begin
            col_l = r_col_index - CW'(1);
            col_r = r_col_index + CW'(1);
        end
    end

    // second row looks up at the first row, which sits in the newer bank
    assign upper_bank = (i_action == ACT_PIXEL && r_row_index == RW'(1)) ? newer : r_older_bank;

    assign push = (r_state == F_CALC) && !i_queue_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (work) n_state = F_RD_NBR;
            end
            F_RD_NBR:  n_state = F_RD_VERT;
            F_RD_VERT: n_state = F_CALC;
            F_CALC: begin
                if (!i_queue_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_RESET;
            r_col_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_data;
                REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= F_IDLE;
            r_older_bank    <= 1'b0;
            r_row_index     <= '0;
            r_col_index     <= '0;
            r_drain_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take && is_drain) begin
                if (row_end) begin
                    r_drain_pending <= 1'b0;
                    r_col_index     <= '0;
                end else begin
                    r_col_index <= r_col_index + CW'(1);
                end
            end else if (take && is_pixel) begin
                if (row_end) begin
                    r_older_bank <= ~r_older_bank;
                    r_col_index  <= '0;
                    if (last_row) begin
                        r_row_index     <= '0;
                        r_drain_pending <= 1'b1;
                    end else begin
                        r_row_index <= r_row_index + RW'(1);
                    end
                end else begin
                    r_col_index <= r_col_index + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_kind   <= i_action;
            r_sample <= i_sample;
            r_last   <= (i_action == ACT_DRAIN) && row_end;
            r_addr_l <= f_addr(newer, col_l);
            r_addr_r <= f_addr(newer, col_r);
            r_addr_u <= f_addr(upper_bank, r_col_index);
            r_addr_c <= f_addr(newer, r_col_index);
            r_addr_w <= f_addr(r_older_bank, r_col_index);
        end
        if (r_state == F_RD_VERT) begin
            r_left  <= r_rd_a;
            r_right <= r_rd_b;
        end
    end

    // line store: two read ports, one write port
    assign rd_en     = (r_state == F_RD_NBR) || (r_state == F_RD_VERT);
    assign rd_addr_a = (r_state == F_RD_NBR) ? r_addr_l : r_addr_u;
    assign rd_addr_b = (r_state == F_RD_NBR) ? r_addr_r : r_addr_c;

    assign wr_en   = store_first || (push && (r_kind == ACT_PIXEL));
    assign wr_addr = store_first ? f_addr(r_older_bank, r_col_index) : r_addr_w;
    assign wr_data = store_first ? i_sample : r_sample;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_line_mem[rd_addr_a];
            r_rd_b <= r_line_mem[rd_addr_b];
        end
    end

    always_comb begin
        o_push.valid          = push;
        o_push.item.grad_x    = $signed({1'b0, r_right}) - $signed({1'b0, r_left});
        o_push.item.grad_y    = (r_kind == ACT_PIXEL)
                              ? $signed({1'b0, r_sample}) - $signed({1'b0, r_rd_a})
                              : $signed({1'b0, r_rd_b}) - $signed({1'b0, r_rd_a});
        o_push.item.frame_end = r_last;
    end

    `IGM_ASSERT(a_drain_after_frame, last_pixel |=> r_drain_pending, "frame end did not arm drain")
    `IGM_ASSERT_NEVER(a_frame_end_on_pixel, push && r_last && (r_kind == ACT_PIXEL), "frame_end on pixel result")

endmodule

### design/igm_queue.sv
// Short FIFO of difference pairs between the front end and the magnitude unit.
`include "image_gradient_magnitude_defines.svh"

module igm_queue
    import igm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_grad_push i_push,
    output logic       o_full,
    output t_grad_push o_head,
    input  logic       i_pop
);

    localparam int unsigned QW = $clog2(QUEUE_DEPTH);

    t_grad_item    r_entries [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full      = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_entries[r_rd_ptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QW+1)'(1);
                2'b01:   r_count <= r_count - (QW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_push.item;
        end
    end

    `IGM_ASSERT_NEVER(a_push_when_full, i_push.valid && o_full, "push into full queue")
    `IGM_ASSERT_NEVER(a_count_range, r_count > (QW+1)'(QUEUE_DEPTH), "queue count overflow")

endmodule

### design/igm_back.sv
// Back end: squares, digit-by-digit square root with rounding, output register.
`include "image_gradient_magnitude_defines.svh"

module igm_back
    import igm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_grad_push               i_head,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [GRAD_W-1:0] o_grad_x,
    output logic signed [GRAD_W-1:0] o_grad_y,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic                     o_frame_end
);

    localparam int unsigned SW = $clog2(ROOT_STEPS);

    t_back_state r_state, n_state;

    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic                     r_last;
    logic [SQ_W-1:0]          r_sx, r_sy;
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_root;
    logic [SW-1:0]            r_step;

    logic                     r_out_valid;
    logic signed [GRAD_W-1:0] r_out_gx, r_out_gy;
    logic [MAG_W-1:0]         r_out_mag;
    logic                     r_out_last;

    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic [REM_W+1:0]           n_cat, n_sub;
    logic                       digit;
    logic [MAG_W-1:0]           root_rnd;
    logic                       out_load;

    assign sq_x     = r_gx * r_gx;
    assign sq_y     = r_gy * r_gy;
    assign n_cat    = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign n_sub    = {1'b0, r_root, 2'b01};
    assign digit    = (n_cat >= n_sub);
    assign root_rnd = (r_rem > {1'b0, r_root}) ? r_root + MAG_W'(1) : r_root;
    assign out_load = (r_state == B_ROUND) && (!r_out_valid || i_ready);
    assign o_pop    = (r_state == B_IDLE) && i_head.valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid) n_state = B_SQUARE;
            end
            B_SQUARE: n_state = B_SUM;
            B_SUM:    n_state = B_ROOT;
            B_ROOT: begin
                if (r_step == SW'(ROOT_STEPS - 1)) n_state = B_ROUND;
            end
            B_ROUND: begin
                if (out_load) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    r_gx   <= i_head.item.grad_x;
                    r_gy   <= i_head.item.grad_y;
                    r_last <= i_head.item.frame_end;
                end
            end
            B_SQUARE: begin
                r_sx <= sq_x[SQ_W-1:0];
                r_sy <= sq_y[SQ_W-1:0];
            end
            B_SUM: begin
                r_rad  <= RAD_W'(r_sx) + RAD_W'(r_sy);
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            B_ROOT: begin
                r_rad  <= r_rad << 2;
                r_rem  <= digit ? REM_W'(n_cat - n_sub) : REM_W'(n_cat);
                r_root <= {r_root[MAG_W-2:0], digit};
                r_step <= r_step + SW'(1);
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_gx   <= r_gx;
            r_out_gy   <= r_gy;
            r_out_mag  <= root_rnd;
            r_out_last <= r_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_grad_x    = r_out_gx;
    assign o_grad_y    = r_out_gy;
    assign o_magnitude = r_out_mag;
    assign o_frame_end = r_out_last;

    `IGM_ASSERT(a_mag_range, out_load |=> (r_out_mag <= MAG_W'(MAG_MAX)), "magnitude out of range")

endmodule

### design/image_gradient_magnitude.sv
// Top level of the central-difference gradient magnitude block.
//
// Input stream (s_axis): one transaction per raster pixel or drain tick.
//   tuser[0] = 0 for a pixel, 1 for a drain tick; tdata[14:0] is the pixel.
// Output stream (m_axis): grad_x, grad_y and magnitude of the pixel one row up,
//   tlast flags the frame's final pixel. Rows 1..N-1 produce results as they
//   arrive; after the last pixel, one drain tick per column flushes the last row.
// Config: write row_count (index 0) and col_count (index 1) while idle; values
//   are clamped to 2..MAX_ROWS / 2..MAX_COLS.
// Flow: a first-row pixel or an ignored transaction leaves the front in F_IDLE; a
//   pixel or drain tick that yields a result holds the input through F_RD_NBR,
//   F_RD_VERT and F_CALC (two line-store reads over the dual-port store, then
//   the difference); F_CALC waits while the queue is full. The magnitude unit
//   resolves one root bit per cycle and pops the next difference pair only once
//   the last result has left B_ROUND. A 4-entry queue sits between the two halves.
// Reset clears positions, bank select and drain state; the line stores need no
//   clearing. When m_axis_tready is low, the output register holds, the root
//   unit waits, then the queue fills and s_axis_tready drops.
module image_gradient_magnitude
    import igm_pkg::*;
#(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [14:0] sample
    input  logic [0:0]           s_axis_tuser,   // [0] action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [15:0] grad_x, [31:16] grad_y, [47:32] magnitude
    output logic                 m_axis_tlast    // frame_end
);

    t_grad_push               front_push, queue_head;
    logic                     queue_full, back_pop;
    logic signed [GRAD_W-1:0] out_gx, out_gy;
    logic [MAG_W-1:0]         out_mag;

    igm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (s_axis_tuser[0]),
        .i_sample     (s_axis_tdata[PIX_W-1:0]),
        .i_queue_full (queue_full),
        .o_push       (front_push)
    );

    igm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_full  (queue_full),
        .o_head  (queue_head),
        .i_pop   (back_pop)
    );

    igm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (queue_head),
        .o_pop       (back_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_grad_x    (out_gx),
        .o_grad_y    (out_gy),
        .o_magnitude (out_mag),
        .o_frame_end (m_axis_tlast)
    );

    assign m_axis_tdata = {out_mag, out_gy, out_gx};

endmodule
